FILE: hw/rtl/aotat_pkg.sv
// ----------------------------------------------------------------------------
// aotat_pkg
// Shared types and constants of the octant annulus tile activity test.
// ----------------------------------------------------------------------------
package aotat_pkg;

    localparam int MW        = 32;  // squaring unit operand width
    localparam int PW        = 64;  // squaring unit product width
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;
    localparam int SIDE_W    = 17;
    localparam int ORG_W     = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_INNER  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTER  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIG_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIG_Y = 3'd4;

    // operand of the shared squaring unit
    typedef enum logic [2:0] {
        MOP_INNER,
        MOP_OUTER,
        MOP_NA,
        MOP_NB,
        MOP_X,
        MOP_TRIAL,
        MOP_ROOT
    } t_mop;

    typedef struct packed {
        logic load;      // capture tile indices
        t_mop mop;
        logic box;       // form box bounds
        logic st_in2;
        logic st_out2;
        logic nc_load;   // load corner pair for norm compare
        logic nc_lo;     // 0: far corner vs inner, 1: near corner vs outer
        logic nc_sa;
        logic nc_sum;
        logic x_init;
        logic x_inc;
        logic st_xsq;
        logic sq_init;
        logic sq_inner;  // root of in2 - x^2 instead of out2 - x^2
        logic sq_step;
        logic st_yub;
        logic st_ylb;
        logic ylb_zero;
    } t_cmd;

    typedef struct packed {
        logic box_miss;
        logic nc_lt;
        logic nc_gt;
        logic ymin_ok;
        logic col_end;
        logic x_far;
        logic xsq_far;
        logic xsq_ge_in2;
        logic bit_zero;
        logic hit;
    } t_sts;

endpackage

FILE: hw/rtl/aotat_dp.sv
// ----------------------------------------------------------------------------
// aotat_dp
// Datapath: config registers, box bounds, shared squaring unit, norm compare,
// bit-serial square root and column range test.
// ----------------------------------------------------------------------------
module aotat_dp #(
    parameter int INDEX_BITS  = 24,
    parameter int RADIUS_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [aotat_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [aotat_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic [INDEX_BITS-1:0]          i_tile_col,
    input  logic [INDEX_BITS-1:0]          i_tile_row,
    input  aotat_pkg::t_cmd                i_cmd,
    output aotat_pkg::t_sts                o_sts
);
    import aotat_pkg::*;

    localparam int RW = RADIUS_BITS;
    localparam int BW = $clog2(RADIUS_BITS);
    localparam int XW = SIDE_W + INDEX_BITS;
    localparam int CW = ((XW > ORG_W) ? XW : ORG_W) + 2;

    logic [RW-1:0]            r_inner, r_outer;
    logic [SIDE_W-1:0]        r_side;
    logic signed [ORG_W-1:0]  r_ox, r_oy;

    logic [INDEX_BITS-1:0]    r_ci, r_cj;
    logic [XW-1:0]            r_pxi, r_pyj;
    logic signed [CW-1:0]     r_xlo, r_xhi, r_ylo, r_yhi, r_x;
    logic signed [CW-1:0]     r_na, r_nb;
    logic                     r_big, r_nc_lo, r_ymin_ok;
    logic [PW-1:0]            r_prod, r_sa, r_in2, r_out2, r_xsq, r_n;
    logic [PW:0]              r_sum;
    logic [MW-1:0]            r_root, r_yub;
    logic [MW:0]              r_ylb;
    logic [BW-1:0]            r_bit;

    logic [MW-1:0]            w_mop, w_trial;
    logic [PW-1:0]            w_sq, w_r2;
    logic signed [CW-1:0]     w_side, w_xlo, w_ylo, w_xs, w_ys, w_ymin;
    logic signed [CW-1:0]     w_lo, w_hi, w_ylb, w_yub, w_outer;

    assign w_side  = $signed({{(CW-SIDE_W){1'b0}}, r_side});
    assign w_xlo   = $signed({{(CW-ORG_W){r_ox[ORG_W-1]}}, r_ox})
                   + $signed({{(CW-XW){1'b0}}, r_pxi});
    assign w_ylo   = $signed({{(CW-ORG_W){r_oy[ORG_W-1]}}, r_oy})
                   + $signed({{(CW-XW){1'b0}}, r_pyj});
    assign w_xs    = r_xlo[CW-1] ? '0 : r_xlo;
    assign w_ys    = r_ylo[CW-1] ? '0 : r_ylo;
    assign w_ymin  = (w_ys > w_xs) ? w_ys : w_xs;
    assign w_trial = r_root | (MW'(1) << r_bit);
    assign w_outer = $signed({{(CW-RW){1'b0}}, r_outer});
    assign w_ylb   = $signed({{(CW-MW-1){1'b0}}, r_ylb});
    assign w_yub   = $signed({{(CW-MW){1'b0}}, r_yub});
    assign w_r2    = r_nc_lo ? r_out2 : r_in2;

    always_comb begin
        case (i_cmd.mop)
            MOP_INNER: w_mop = MW'(r_inner);
            MOP_OUTER: w_mop = MW'(r_outer);
            MOP_NA:    w_mop = r_na[MW-1:0];
            MOP_NB:    w_mop = r_nb[MW-1:0];
            MOP_X:     w_mop = r_x[MW-1:0];
            MOP_TRIAL: w_mop = w_trial;
            MOP_ROOT:  w_mop = r_root;
            default:   w_mop = '0;
        endcase
    end
    assign w_sq = w_mop * w_mop;

    // lower and upper ends of the admissible y range for this column
    always_comb begin
        w_lo = (r_x > r_ylo) ? r_x : r_ylo;
        if (w_ylb > w_lo) begin
            w_lo = w_ylb;
        end
        w_hi = (w_yub < r_yhi) ? w_yub : r_yhi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner <= RW'(1);
            r_outer <= RW'(2);
            r_side  <= SIDE_W'(256);
            r_ox    <= ORG_W'(1);
            r_oy    <= ORG_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_INNER:  r_inner <= i_cfg_data[RW-1:0];
                CFG_OUTER:  r_outer <= i_cfg_data[RW-1:0];
                CFG_SIDE:   r_side  <= i_cfg_data[SIDE_W-1:0];
                CFG_ORIG_X: r_ox    <= $signed(i_cfg_data[ORG_W-1:0]);
                CFG_ORIG_Y: r_oy    <= $signed(i_cfg_data[ORG_W-1:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_sq;
        r_pxi  <= r_side * r_ci;
        r_pyj  <= r_side * r_cj;
        if (i_cmd.load) begin
            r_ci <= i_tile_col;
            r_cj <= i_tile_row;
        end
        if (i_cmd.box) begin
            r_xlo <= w_xlo;
            r_xhi <= w_xlo + w_side;
            r_ylo <= w_ylo;
            r_yhi <= w_ylo + w_side;
        end
        if (i_cmd.st_in2)  r_in2  <= r_prod;
        if (i_cmd.st_out2) r_out2 <= r_prod;
        if (i_cmd.nc_load) begin
            r_nc_lo   <= i_cmd.nc_lo;
            r_ymin_ok <= (w_ymin <= r_yhi);
            if (i_cmd.nc_lo) begin
                r_na <= w_xs;
                r_nb <= w_ymin;
                r_big <= (|w_xs[CW-1:MW]) | (|w_ymin[CW-1:MW]);
            end else begin
                r_na <= r_xhi[CW-1] ? '0 : r_xhi;
                r_nb <= r_yhi[CW-1] ? '0 : r_yhi;
                r_big <= (!r_xhi[CW-1] && (|r_xhi[CW-2:MW]))
                       | (!r_yhi[CW-1] && (|r_yhi[CW-2:MW]));
            end
        end
        if (i_cmd.nc_sa)  r_sa  <= r_prod;
        if (i_cmd.nc_sum) r_sum <= {1'b0, r_sa} + {1'b0, r_prod};
        if (i_cmd.x_init) r_x <= w_xs;
        if (i_cmd.x_inc)  r_x <= r_x + CW'(1);
        if (i_cmd.st_xsq) r_xsq <= r_prod;
        if (i_cmd.sq_init) begin
            r_n    <= i_cmd.sq_inner ? (r_in2 - r_xsq) : (r_out2 - r_xsq);
            r_root <= '0;
            r_bit  <= BW'(RADIUS_BITS - 1);
        end
        if (i_cmd.sq_step) begin
            if (r_prod <= r_n) begin
                r_root <= w_trial;
            end
            r_bit <= r_bit - BW'(1);
        end
        if (i_cmd.st_yub)   r_yub <= r_root;
        if (i_cmd.st_ylb)   r_ylb <= {1'b0, r_root} + {{MW{1'b0}}, (r_prod < r_n)};
        if (i_cmd.ylb_zero) r_ylb <= '0;
    end

    always_comb begin
        o_sts.box_miss   = r_xhi[CW-1] || (r_yhi < r_xlo);
        o_sts.nc_lt      = !r_big && (r_sum < {1'b0, w_r2});
        o_sts.nc_gt      = r_big || (r_sum > {1'b0, w_r2});
        o_sts.ymin_ok    = r_ymin_ok;
        o_sts.col_end    = r_x > r_xhi;
        o_sts.x_far      = r_x > w_outer;
        o_sts.xsq_far    = r_xsq > r_out2;
        o_sts.xsq_ge_in2 = r_xsq >= r_in2;
        o_sts.bit_zero   = (r_bit == '0);
        o_sts.hit        = (w_lo <= w_hi);
    end

endmodule

FILE: hw/rtl/aotat_ctrl.sv
// ----------------------------------------------------------------------------
// aotat_ctrl
// Controller: sequences screen, column scan and square roots; holds the
// output word register.
// ----------------------------------------------------------------------------
module aotat_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output logic            o_active,
    output logic            o_screened,
    output aotat_pkg::t_cmd o_cmd,
    input  aotat_pkg::t_sts i_sts
);
    import aotat_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_MUL, ST_BOX, ST_SCR1,
        ST_NC_A, ST_NC_B, ST_NC_C, ST_NC_D,
        ST_COL, ST_XSQ, ST_XCHK,
        ST_SQ_M, ST_SQ_C, ST_SQ_END, ST_CEIL,
        ST_TEST, ST_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_phase, n_phase;
    logic   r_sqin, n_sqin;
    logic   r_res_act, n_res_act, r_res_scr, n_res_scr;
    logic   r_mvalid, n_mvalid, r_oact, n_oact, r_oscr, n_oscr;

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_mvalid;
    assign o_active   = r_oact;
    assign o_screened = r_oscr;

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_sqin    = r_sqin;
        n_res_act = r_res_act;
        n_res_scr = r_res_scr;
        n_mvalid  = r_mvalid & ~i_m_tready;
        n_oact    = r_oact;
        n_oscr    = r_oscr;
        o_cmd     = '0;
        o_cmd.mop = MOP_INNER;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mop = MOP_INNER;
                n_state   = ST_BOX;
            end
            ST_BOX: begin
                o_cmd.box    = 1'b1;
                o_cmd.st_in2 = 1'b1;
                o_cmd.mop    = MOP_OUTER;
                n_state      = ST_SCR1;
            end
            ST_SCR1: begin
                o_cmd.st_out2 = 1'b1;
                if (i_sts.box_miss) begin
                    n_res_act = 1'b0;
                    n_res_scr = 1'b1;
                    n_state   = ST_DONE;
                end else begin
                    o_cmd.nc_load = 1'b1;
                    n_phase       = 1'b0;
                    n_state       = ST_NC_A;
                end
            end
            ST_NC_A: begin
                o_cmd.mop = MOP_NA;
                n_state   = ST_NC_B;
            end
            ST_NC_B: begin
                o_cmd.nc_sa = 1'b1;
                o_cmd.mop   = MOP_NB;
                n_state     = ST_NC_C;
            end
            ST_NC_C: begin
                o_cmd.nc_sum = 1'b1;
                n_state      = ST_NC_D;
            end
            ST_NC_D: begin
                if (!r_phase) begin
                    // far corner still inside the inner circle
                    if (i_sts.nc_lt) begin
                        n_res_act = 1'b0;
                        n_res_scr = 1'b1;
                        n_state   = ST_DONE;
                    end else begin
                        o_cmd.nc_load = 1'b1;
                        o_cmd.nc_lo   = 1'b1;
                        n_phase       = 1'b1;
                        n_state       = ST_NC_A;
                    end
                end else if (i_sts.ymin_ok && i_sts.nc_gt) begin
                    n_res_act = 1'b0;
                    n_res_scr = 1'b1;
                    n_state   = ST_DONE;
                end else begin
                    o_cmd.x_init = 1'b1;
                    n_state      = ST_COL;
                end
            end
            ST_COL: begin
                if (i_sts.col_end || i_sts.x_far) begin
                    n_res_act = 1'b0;
                    n_res_scr = 1'b0;
                    n_state   = ST_DONE;
                end else begin
                    o_cmd.mop = MOP_X;
                    n_state   = ST_XSQ;
                end
            end
            ST_XSQ: begin
                o_cmd.st_xsq = 1'b1;
                n_state      = ST_XCHK;
            end
            ST_XCHK: begin
                if (i_sts.xsq_far) begin
                    n_res_act = 1'b0;
                    n_res_scr = 1'b0;
                    n_state   = ST_DONE;
                end else begin
                    o_cmd.sq_init = 1'b1;
                    n_sqin        = 1'b0;
                    n_state       = ST_SQ_M;
                end
            end
            ST_SQ_M: begin
                o_cmd.mop = MOP_TRIAL;
                n_state   = ST_SQ_C;
            end
            ST_SQ_C: begin
                o_cmd.sq_step = 1'b1;
                n_state       = i_sts.bit_zero ? ST_SQ_END : ST_SQ_M;
            end
            ST_SQ_END: begin
                if (!r_sqin) begin
                    o_cmd.st_yub = 1'b1;
                    if (i_sts.xsq_ge_in2) begin
                        o_cmd.ylb_zero = 1'b1;
                        n_state        = ST_TEST;
                    end else begin
                        o_cmd.sq_init  = 1'b1;
                        o_cmd.sq_inner = 1'b1;
                        n_sqin         = 1'b1;
                        n_state        = ST_SQ_M;
                    end
                end else begin
                    // ceiling root: floor root plus one unless exact
                    o_cmd.mop = MOP_ROOT;
                    n_state   = ST_CEIL;
                end
            end
            ST_CEIL: begin
                o_cmd.st_ylb = 1'b1;
                n_state      = ST_TEST;
            end
            ST_TEST: begin
                if (i_sts.hit) begin
                    n_res_act = 1'b1;
                    n_res_scr = 1'b0;
                    n_state   = ST_DONE;
                end else begin
                    o_cmd.x_inc = 1'b1;
                    n_state     = ST_COL;
                end
            end
            ST_DONE: begin
                if (!r_mvalid || i_m_tready) begin
                    n_mvalid = 1'b1;
                    n_oact   = r_res_act;
                    n_oscr   = r_res_scr;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_phase   <= 1'b0;
            r_sqin    <= 1'b0;
            r_res_act <= 1'b0;
            r_res_scr <= 1'b0;
            r_mvalid  <= 1'b0;
            r_oact    <= 1'b0;
            r_oscr    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_sqin    <= n_sqin;
            r_res_act <= n_res_act;
            r_res_scr <= n_res_scr;
            r_mvalid  <= n_mvalid;
            r_oact    <= n_oact;
            r_oscr    <= n_oscr;
        end
    end

`ifndef SYNTHESIS
    a_scr_not_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mvalid |-> !(r_oact && r_oscr))
        else $error("screened word marked active");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mvalid && !i_m_tready |=> r_mvalid && $stable(r_oact) && $stable(r_oscr))
        else $error("stalled output word changed");

    a_sqrt_loop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQ_C) && !i_sts.bit_zero |=> (r_state == ST_SQ_M))
        else $error("root search left early");
`endif

endmodule

FILE: hw/rtl/annulus_octant_tile_activity_test.sv
// ----------------------------------------------------------------------------
// annulus_octant_tile_activity_test
// Tests whether a tile box holds a lattice point of the octant annulus.
// ----------------------------------------------------------------------------
//  channel   direction  word
//  s         in         tile_col, tile_row
//  m         out        active, screened
//  cfg       in         register index, data
//
//  A screened tile skips the column scan and goes straight to the result word.
//  Each scanned column takes one root search, or two when the inner root is
//  needed, all on the single shared squaring unit; up to tile_side + 1 columns.
//  Synchronous active-low reset, no clearing pass. One tile at a time; the next
//  is taken while a result waits on m.
// ----------------------------------------------------------------------------
module annulus_octant_tile_activity_test #(
    parameter int INDEX_BITS  = 24,
    parameter int RADIUS_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [aotat_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [aotat_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // tile_col, tile_row, zero pad
    input  logic [((2*INDEX_BITS+7)/8)*8-1:0] i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // active, screened, zero pad
    output logic [7:0]                      o_m_tdata
);
    import aotat_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_active, w_screened;

    aotat_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_active   (w_active),
        .o_screened (w_screened),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    aotat_dp #(
        .INDEX_BITS  (INDEX_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_tile_col (i_s_tdata[INDEX_BITS-1:0]),
        .i_tile_row (i_s_tdata[2*INDEX_BITS-1:INDEX_BITS]),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts)
    );

    assign o_m_tdata = {6'b0, w_screened, w_active};

endmodule
